/* design/waq_pkg.sv */
// ----------------------------------------------------------------------------
// waq_pkg
// Shared types and constants for the worker admission queue.
// ----------------------------------------------------------------------------
package waq_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned ID_W      = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned WORKERS_W = 16;
  localparam int unsigned WAITCFG_W = 7;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned WCOUNT_W  = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Timeout limit in milliseconds: seconds times one thousand.
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned MSMUL_W    = 10;
  localparam int unsigned LIMIT_W    = 26;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORKERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAITING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;

  // Input item kinds.
  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_START    = 3'd0,
    VERDICT_QUEUED   = 3'd1,
    VERDICT_REJECTED = 3'd2,
    VERDICT_DISPATCH = 3'd3,
    VERDICT_TIMEOUT  = 3'd4,
    VERDICT_FREED    = 3'd5
  } verdict_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;  // capture the accepted input item
    logic rd_en;    // read the queue head entry
    logic commit;   // update state and load the output register
  } waq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic dispatch; // finish item that pops the queue head
    logic out_free; // output register can take a result this cycle
  } waq_status_t;

endpackage

/* design/waq_ram.sv */
// ----------------------------------------------------------------------------
// waq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module waq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/waq_ctrl.sv */
// ----------------------------------------------------------------------------
// waq_ctrl
// Sequencer: accept an item, read the queue head when needed, commit.
// ----------------------------------------------------------------------------
module waq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  waq_pkg::waq_status_t status_i,
  output waq_pkg::waq_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.load_in = 1'b0;
    cmd_o.rd_en   = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        // The head entry is read only when the item will pop it.
        cmd_o.rd_en = status_i.dispatch;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/waq_dp.sv */
// ----------------------------------------------------------------------------
// waq_dp
// Datapath: configuration, counters, queue pointers, wait queue RAM and the
// output register.
// ----------------------------------------------------------------------------
module waq_dp #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [waq_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [waq_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  input  logic                                mode_i,
  input  logic [waq_pkg::ID_W-1:0]            request_id_i,
  input  logic [waq_pkg::TIME_W-1:0]          now_ms_i,
  input  waq_pkg::waq_cmd_t                   cmd_i,
  output waq_pkg::waq_status_t                status_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [waq_pkg::VERDICT_W-1:0]       verdict_o,
  output logic [waq_pkg::ID_W-1:0]            result_id_o,
  output logic [waq_pkg::WORKERS_W-1:0]       active_count_o,
  output logic [waq_pkg::WCOUNT_W-1:0]        waiting_count_o
);

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W   = (CNT_W > waq_pkg::WAITCFG_W) ? CNT_W : waq_pkg::WAITCFG_W;
  localparam int unsigned ENTRY_W = waq_pkg::ID_W + waq_pkg::TIME_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);

  // Configuration.
  logic [waq_pkg::WORKERS_W-1:0] max_workers_q;
  logic [waq_pkg::WAITCFG_W-1:0] max_waiting_q;
  logic [waq_pkg::LIMIT_W-1:0]   limit_q;

  // Latched input item.
  logic                          mode_q;
  logic [waq_pkg::ID_W-1:0]      id_q;
  logic [waq_pkg::TIME_W-1:0]    now_q;

  // Queue and worker state.
  logic [PTR_W-1:0]              head_q, head_d;
  logic [PTR_W-1:0]              tail_q, tail_d;
  logic [CNT_W-1:0]              total_q, total_d;
  logic [waq_pkg::WORKERS_W-1:0] act_q, act_d, act_inc, act_dec;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  waq_pkg::verdict_e             verdict_q, verdict_d;
  logic [waq_pkg::ID_W-1:0]      rid_q, rid_d;
  logic [waq_pkg::WORKERS_W-1:0] oact_q;
  logic [waq_pkg::WCOUNT_W-1:0]  owait_q;

  logic                          slot_free, may_dispatch, has_room, dispatch, timed_out;
  logic [CMP_W-1:0]              cap;
  logic                          ram_we;
  logic [ENTRY_W-1:0]            ram_rdata;
  logic [waq_pkg::ID_W-1:0]      head_id;
  logic [waq_pkg::TIME_W-1:0]    head_time, waited;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_workers_q <= '0;
      max_waiting_q <= '0;
      limit_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        waq_pkg::CFG_MAX_WORKERS: max_workers_q <= cfg_data_i;
        waq_pkg::CFG_MAX_WAITING: max_waiting_q <= cfg_data_i[waq_pkg::WAITCFG_W-1:0];
        waq_pkg::CFG_TIMEOUT: begin
          limit_q <= waq_pkg::LIMIT_W'(cfg_data_i *
                                       waq_pkg::MSMUL_W'(waq_pkg::MS_PER_SEC));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i;
      id_q   <= request_id_i;
      now_q  <= now_ms_i;
    end
  end

  always_comb begin
    slot_free    = (max_workers_q == '0) || (act_q < max_workers_q);
    may_dispatch = (max_workers_q == '0) || (act_q <= max_workers_q);
    if ((max_waiting_q == '0) || (CMP_W'(max_waiting_q) > DEPTH_CMP)) begin
      cap = DEPTH_CMP;
    end else begin
      cap = CMP_W'(max_waiting_q);
    end
    has_room = CMP_W'(total_q) < cap;
    dispatch = (mode_q == waq_pkg::MODE_FINISH) && may_dispatch && (total_q != '0);

    head_id   = ram_rdata[ENTRY_W-1 -: waq_pkg::ID_W];
    head_time = ram_rdata[waq_pkg::TIME_W-1:0];
    waited    = now_q - head_time;
    timed_out = waited > waq_pkg::TIME_W'(limit_q);

    act_inc = (act_q != '1) ? act_q + 1'b1 : act_q;
    act_dec = (act_q != '0) ? act_q - 1'b1 : act_q;
  end

  assign ram_we = cmd_i.commit && (mode_q == waq_pkg::MODE_ARRIVE) && !slot_free && has_room;

  waq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i ({id_q, now_q}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    total_d   = total_q;
    act_d     = act_q;
    verdict_d = verdict_q;
    rid_d     = rid_q;
    if (cmd_i.commit) begin
      if (mode_q == waq_pkg::MODE_ARRIVE) begin
        rid_d = id_q;
        if (slot_free) begin
          act_d     = act_inc;
          verdict_d = waq_pkg::VERDICT_START;
        end else if (has_room) begin
          tail_d    = (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
          total_d   = total_q + 1'b1;
          verdict_d = waq_pkg::VERDICT_QUEUED;
        end else begin
          verdict_d = waq_pkg::VERDICT_REJECTED;
        end
      end else if (dispatch) begin
        rid_d   = head_id;
        head_d  = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
        total_d = total_q - 1'b1;
        if (timed_out) begin
          act_d     = act_dec;
          verdict_d = waq_pkg::VERDICT_TIMEOUT;
        end else begin
          verdict_d = waq_pkg::VERDICT_DISPATCH;
        end
      end else begin
        rid_d     = '0;
        act_d     = act_dec;
        verdict_d = waq_pkg::VERDICT_FREED;
      end
    end
  end

  assign out_valid_d = cmd_i.commit ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      total_q     <= '0;
      act_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      total_q     <= total_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      verdict_q <= verdict_d;
      rid_q     <= rid_d;
      oact_q    <= act_d;
      owait_q   <= waq_pkg::WCOUNT_W'(total_d);
    end
  end

  assign status_o.dispatch = dispatch;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign verdict_o       = verdict_q;
  assign result_id_o     = rid_q;
  assign active_count_o  = oact_q;
  assign waiting_count_o = owait_q;

endmodule

/* design/worker_admission_queue_core.sv */
// ----------------------------------------------------------------------------
// worker_admission_queue_core
// Admission controller with a worker slot limit and a bounded wait queue.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   -----------------------------------
//   input     in_valid_i / in_stall_o   mode_i, request_id_i, now_ms_i
//   output    out_valid_o / out_stall_i verdict_o, result_id_o,
//                                       active_count_o, waiting_count_o
//   config    cfg_we_i                  cfg_index_i, cfg_data_i
//
// Each item passes an accepting cycle, a check cycle in which the queue
// head is read from the RAM if the item pops it, and a commit cycle in
// which counters, pointers and the queue write are updated. The registered
// RAM read is why the check cycle exists. The commit waits while the
// output register holds a stalled result; no new item is accepted until
// the commit. Reset clears the counters, pointers and configuration; the
// queue RAM is not cleared, since only entries that were written are ever read.
//
// An arriving request starts at once when a worker slot is free, which is
// always the case when the slot limit is zero. Otherwise it is queued with
// its arrival time if the queue is below its cap, and rejected if not. The
// cap is max_waiting, or the physical depth when that register is zero or
// larger than the depth. A finishing worker hands its slot to the queue
// head unless the active count is above the limit; a head that waited longer
// than the timeout (in seconds times one thousand) is reported as timed out
// and its slot is freed instead. With no head to dispatch, the finish simply
// frees a slot. The active count saturates at both ends.
// ----------------------------------------------------------------------------
module worker_admission_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [waq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [waq_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [waq_pkg::ID_W-1:0]          request_id_i,
  input  logic [waq_pkg::TIME_W-1:0]        now_ms_i,
  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [waq_pkg::VERDICT_W-1:0]     verdict_o,
  output logic [waq_pkg::ID_W-1:0]          result_id_o,
  output logic [waq_pkg::WORKERS_W-1:0]     active_count_o,
  output logic [waq_pkg::WCOUNT_W-1:0]      waiting_count_o
);

  waq_pkg::waq_cmd_t    cmd;
  waq_pkg::waq_status_t status;

  // The sequencer owns the input handshake and decides when to commit.
  waq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the queue, counter and configuration state and the output register.
  waq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .request_id_i    (request_id_i),
    .now_ms_i        (now_ms_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .verdict_o       (verdict_o),
    .result_id_o     (result_id_o),
    .active_count_o  (active_count_o),
    .waiting_count_o (waiting_count_o)
  );

  // Only one item is in flight: a transfer closes the input until commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // Every commit presents a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("commit did not produce a result");

  // A commit never overwrites a result that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

  // A freed slot carries no request identifier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (verdict_o == waq_pkg::VERDICT_FREED)) |-> (result_id_o == '0))
    else $error("slot freed result with nonzero identifier");

endmodule

/* tb/worker_admission_queue_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worker_admission_queue_core_test
// Self-checking bench for the admission queue: a short directed script, six
// randomized phases under different register settings, a burst with unlimited
// slots and no idle cycles on either side, then a mixed load at the top limit.
// Each result is checked field by field against the predictor or a pinned value.
// ----------------------------------------------------------------------------
module worker_admission_queue_core_test;

  localparam int unsigned QDEPTH      = 64;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned MAX_GAP     = 18;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 195;
  localparam int unsigned BURST_ITEMS = 40;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned SCRIPT_ROWS = 40;
  localparam int unsigned WANT_DEPTH  = 8;
  localparam int unsigned WANT_IDX_W  = 3;

  // One result transfer as the output channel presents it.
  typedef struct packed {
    waq_pkg::verdict_e                 verdict;
    logic [waq_pkg::ID_W-1:0]          id;
    logic [waq_pkg::WORKERS_W-1:0]     active;
    logic [waq_pkg::WCOUNT_W-1:0]      waiting;
  } outcome_t;

  // A row of the directed script: either a register write or one input item,
  // optionally with its result typed in by hand.
  typedef struct {
    logic                              is_reg;
    logic [waq_pkg::CFG_IDX_W-1:0]     reg_idx;
    logic [waq_pkg::CFG_DAT_W-1:0]     reg_val;
    logic                              kind;
    logic [waq_pkg::ID_W-1:0]          id;
    logic [waq_pkg::TIME_W-1:0]        stamp;
    logic                              pinned;
    outcome_t                          want;
  } script_row_t;

  // --------------------------------------------------------------------------
  // Stimulus and observed signals. Everything the bench drives starts known.
  // --------------------------------------------------------------------------
  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              cfg_we    = 1'b0;
  logic [waq_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [waq_pkg::CFG_DAT_W-1:0]     cfg_data  = '0;
  logic                              in_valid  = 1'b0;
  logic                              in_stall;
  logic                              mode      = waq_pkg::MODE_ARRIVE;
  logic [waq_pkg::ID_W-1:0]          req_id    = '0;
  logic [waq_pkg::TIME_W-1:0]        now_ms    = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [waq_pkg::VERDICT_W-1:0]     verdict;
  logic [waq_pkg::ID_W-1:0]          result_id;
  logic [waq_pkg::WORKERS_W-1:0]     active_count;
  logic [waq_pkg::WCOUNT_W-1:0]      waiting_count;

  // Hand-typed expectation that travels with the item currently offered.
  logic                              pin_valid = 1'b0;
  outcome_t                          pin_want  = '0;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the wait line, the slot count and the
  // three registers. The line and the count change once per accepted item.
  // --------------------------------------------------------------------------
  logic [waq_pkg::ID_W-1:0]          line_ids   [QDEPTH];
  logic [waq_pkg::TIME_W-1:0]        line_since [QDEPTH];
  logic [QPTR_W-1:0]                 line_head  = '0;
  logic [QPTR_W-1:0]                 line_tail  = '0;
  logic [waq_pkg::WCOUNT_W-1:0]      line_total = '0;
  logic [waq_pkg::WORKERS_W-1:0]     busy_slots = '0;
  logic [waq_pkg::WORKERS_W-1:0]     slot_limit = '0;
  logic [waq_pkg::WAITCFG_W-1:0]     line_limit = '0;
  logic [waq_pkg::TIMEOUT_W-1:0]     patience_s = '0;

  // Results predicted for accepted items, oldest first, in a small ring.
  outcome_t                          want_ring [WANT_DEPTH];
  int unsigned                       want_wr    = 0;
  int unsigned                       want_rd    = 0;
  script_row_t                       script [SCRIPT_ROWS];
  int unsigned                       script_len = 0;

  int unsigned           cycles       = 0;
  int unsigned           failures     = 0;
  int unsigned           results_seen = 0;
  int unsigned           taken_seen   = 0;
  int unsigned           recv_wait    = 0;
  int unsigned           recv_burst   = 0;
  int unsigned           send_burst   = 0;
  // Set while both sides must run flat out.
  logic                  no_idle      = 1'b0;

  worker_admission_queue_core #(
    .QUEUE_DEPTH     (QDEPTH)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .request_id_i    (req_id),
    .now_ms_i        (now_ms),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .verdict_o       (verdict),
    .result_id_o     (result_id),
    .active_count_o  (active_count),
    .waiting_count_o (waiting_count)
  );

  always #1 clk = ~clk;

  // The watchdog covers both a hung handshake and a result that never comes.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor. Works out the result of one item and advances the private
  // state. An arrival starts when a slot is free (always, with no limit), is
  // queued while the line is below its cap, and is rejected otherwise. A
  // finish hands the slot to the line head unless the count is above the
  // limit; a head that waited past the timeout is reported as timed out and
  // gives the slot back. The count saturates at both ends.
  // --------------------------------------------------------------------------
  function automatic outcome_t admission_outcome(logic kind,
                                                 logic [waq_pkg::ID_W-1:0] id,
                                                 logic [waq_pkg::TIME_W-1:0] stamp);
    outcome_t                      r;
    logic [waq_pkg::WCOUNT_W-1:0]  cap;
    logic [waq_pkg::TIME_W-1:0]    waited;
    logic [waq_pkg::TIME_W-1:0]    allowed;
    r.id = id;
    if (kind == waq_pkg::MODE_ARRIVE) begin
      if (slot_limit == 0 || busy_slots < slot_limit) begin
        if (busy_slots != '1) busy_slots++;
        r.verdict = waq_pkg::VERDICT_START;
      end else begin
        // A cap of zero, or one beyond the physical line, means the full line.
        cap = (line_limit == 0 || line_limit > QDEPTH) ?
              waq_pkg::WCOUNT_W'(QDEPTH) : line_limit;
        if (line_total < cap) begin
          line_ids[line_tail]   = id;
          line_since[line_tail] = stamp;
          line_tail++;
          line_total++;
          r.verdict = waq_pkg::VERDICT_QUEUED;
        end else begin
          r.verdict = waq_pkg::VERDICT_REJECTED;
        end
      end
    end else if ((slot_limit == 0 || busy_slots <= slot_limit) && line_total != 0) begin
      r.id    = line_ids[line_head];
      // The wait is measured modulo 2^32, so a clock wrap is harmless.
      waited  = stamp - line_since[line_head];
      allowed = waq_pkg::TIME_W'(patience_s) * waq_pkg::TIME_W'(waq_pkg::MS_PER_SEC);
      line_head++;
      line_total--;
      if (waited > allowed) begin
        if (busy_slots != 0) busy_slots--;
        r.verdict = waq_pkg::VERDICT_TIMEOUT;
      end else begin
        // The head inherits the finished slot, so the count stays put.
        r.verdict = waq_pkg::VERDICT_DISPATCH;
      end
    end else begin
      if (busy_slots != 0) busy_slots--;
      r.verdict = waq_pkg::VERDICT_FREED;
      r.id      = '0;
    end
    r.active  = busy_slots;
    r.waiting = line_total;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and scoreboard, all at the rising edge: register writes update
  // the predictor's copy, an accepted item queues its expectation, and a
  // result transfer is checked against the oldest one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (cfg_we) begin
      case (cfg_index)
        waq_pkg::CFG_MAX_WORKERS: slot_limit = cfg_data[waq_pkg::WORKERS_W-1:0];
        waq_pkg::CFG_MAX_WAITING: line_limit = cfg_data[waq_pkg::WAITCFG_W-1:0];
        waq_pkg::CFG_TIMEOUT:     patience_s = cfg_data[waq_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
    if (in_valid && !in_stall) begin
      // The predictor always runs so that its state tracks the block, even
      // when the script supplies the expected result by hand.
      want = admission_outcome(mode, req_id, now_ms);
      want_ring[want_wr[WANT_IDX_W-1:0]] = pin_valid ? pin_want : want;
      want_wr++;
    end
    if (out_valid && !out_stall) begin
      results_seen++;
      got.verdict = waq_pkg::verdict_e'(verdict);
      got.id      = result_id;
      got.active  = active_count;
      got.waiting = waiting_count;
      if (want_wr == want_rd) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("%0t: unexpected result verdict %0d id %h active %0d waiting %0d",
                   $time, verdict, result_id, active_count, waiting_count);
      end else begin
        want = want_ring[want_rd[WANT_IDX_W-1:0]];
        want_rd++;
        if (got.verdict !== want.verdict || got.id !== want.id ||
            got.active !== want.active || got.waiting !== want.waiting) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("%0t: expected %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                     $time, want.verdict, want.id, want.active, want.waiting,
                     verdict, result_id, active_count, waiting_count);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. After each result transfer it draws how long to hold off the
  // next one; now and then it runs a stretch with no stall at all.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (results_seen != taken_seen) begin
      taken_seen = results_seen;
      if (no_idle || recv_burst != 0) recv_wait = 0;
      else recv_wait = $urandom_range(0, MAX_GAP);
      if (recv_burst != 0) recv_burst--;
      else if ($urandom_range(0, 24) == 0) recv_burst = $urandom_range(10, 40);
    end
    out_stall <= (recv_wait != 0);
    if (recv_wait != 0) recv_wait--;
  end

  // Offers one item after a random gap and returns at the edge where the
  // transfer takes place. Valid stays high until the next falling edge, where
  // the next item replaces the payload or something else lowers it.
  task automatic send_item(logic kind, logic [waq_pkg::ID_W-1:0] id,
                           logic [waq_pkg::TIME_W-1:0] stamp,
                           logic pinned, outcome_t pinned_want);
    int unsigned gap;
    if (no_idle || send_burst != 0) gap = 0;
    else gap = $urandom_range(0, MAX_GAP);
    if (send_burst != 0) send_burst--;
    else if ($urandom_range(0, 24) == 0) send_burst = $urandom_range(10, 40);
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    mode      <= kind;
    req_id    <= id;
    now_ms    <= stamp;
    pin_valid <= pinned;
    pin_want  <= pinned_want;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering items and waits until every predicted result has arrived.
  task automatic wait_for_quiet();
    @(negedge clk) in_valid <= 1'b0;
    while (want_wr != want_rd) @(posedge clk);
  endtask

  // Register writes happen only once the block is idle and every result is in.
  task automatic write_reg(logic [waq_pkg::CFG_IDX_W-1:0] idx,
                           logic [waq_pkg::CFG_DAT_W-1:0] value);
    wait_for_quiet();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic void row_reg(logic [waq_pkg::CFG_IDX_W-1:0] idx,
                                  logic [waq_pkg::CFG_DAT_W-1:0] value);
    script_row_t row;
    row         = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = value;
    script[script_len] = row;
    script_len++;
  endfunction

  function automatic void row_item(logic kind, logic [waq_pkg::ID_W-1:0] id,
                                   logic [waq_pkg::TIME_W-1:0] stamp);
    script_row_t row;
    row       = '{default: '0};
    row.kind  = kind;
    row.id    = id;
    row.stamp = stamp;
    script[script_len] = row;
    script_len++;
  endfunction

  function automatic void row_pinned(logic kind, logic [waq_pkg::ID_W-1:0] id,
                                     logic [waq_pkg::TIME_W-1:0] stamp,
                                     waq_pkg::verdict_e v,
                                     logic [waq_pkg::ID_W-1:0] rid,
                                     logic [waq_pkg::WORKERS_W-1:0] act,
                                     logic [waq_pkg::WCOUNT_W-1:0] waiting);
    script_row_t row;
    row              = '{default: '0};
    row.kind         = kind;
    row.id           = id;
    row.stamp        = stamp;
    row.pinned       = 1'b1;
    row.want.verdict = v;
    row.want.id      = rid;
    row.want.active  = act;
    row.want.waiting = waiting;
    script[script_len] = row;
    script_len++;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [waq_pkg::TIME_W-1:0]    clock_ms;
    logic [waq_pkg::TIME_W-1:0]    stamp;
    logic [waq_pkg::WORKERS_W-1:0] worker_cap;
    logic [waq_pkg::CFG_DAT_W-1:0] line_cap;
    logic [waq_pkg::TIMEOUT_W-1:0] wait_secs;
    int unsigned                   arrive_pct;
    logic                          kind;

    // Directed script. Right after reset there is no limit, the line cap is
    // the full depth and the timeout is zero.
    // A finish with nothing running leaves the count at zero.
    row_pinned(waq_pkg::MODE_FINISH, 16'h0000, 32'h0000_0000,
               waq_pkg::VERDICT_FREED, 16'h0000, 16'd0, 7'd0);
    row_pinned(waq_pkg::MODE_ARRIVE, 16'hFFFF, 32'hFFFF_FFFF,
               waq_pkg::VERDICT_START, 16'hFFFF, 16'd1, 7'd0);
    row_pinned(waq_pkg::MODE_ARRIVE, 16'h0000, 32'h0000_0000,
               waq_pkg::VERDICT_START, 16'h0000, 16'd2, 7'd0);
    // Two slots, a line of one: the next arrival waits, the one after bounces.
    row_reg(waq_pkg::CFG_MAX_WORKERS, 16'd2);
    row_reg(waq_pkg::CFG_MAX_WAITING, 16'd1);
    row_pinned(waq_pkg::MODE_ARRIVE, 16'h1234, 32'hFFFF_FFF0,
               waq_pkg::VERDICT_QUEUED, 16'h1234, 16'd2, 7'd1);
    row_pinned(waq_pkg::MODE_ARRIVE, 16'h5678, 32'h0000_0005,
               waq_pkg::VERDICT_REJECTED, 16'h5678, 16'd2, 7'd1);
    // The request field of a finish is ignored; zero wait is within a zero
    // timeout.
    row_pinned(waq_pkg::MODE_FINISH, 16'hBEEF, 32'hFFFF_FFF0,
               waq_pkg::VERDICT_DISPATCH, 16'h1234, 16'd2, 7'd0);
    // A cap beyond the physical depth, and the longest timeout. The first
    // head waits exactly the limit across a clock wrap, the second one more.
    row_reg(waq_pkg::CFG_MAX_WAITING, 16'd100);
    row_reg(waq_pkg::CFG_TIMEOUT, 16'hFFFF);
    row_item(waq_pkg::MODE_ARRIVE, 16'hAAAA, 32'hFFFF_FFF0);
    row_item(waq_pkg::MODE_ARRIVE, 16'h5555, 32'hFFFF_FFF8);
    row_item(waq_pkg::MODE_FINISH, 16'h0000, 32'hFFFF_FFF0 + 32'd65_535_000);
    row_item(waq_pkg::MODE_FINISH, 16'h0000, 32'hFFFF_FFF8 + 32'd65_535_001);
    // Lowering the limit below the count: the finish frees a slot even with
    // a request waiting, and the next finish dispatches it.
    row_item(waq_pkg::MODE_ARRIVE, 16'h0001, 32'd1000);
    row_item(waq_pkg::MODE_ARRIVE, 16'h0002, 32'd1000);
    row_reg(waq_pkg::CFG_MAX_WORKERS, 16'd1);
    row_item(waq_pkg::MODE_FINISH, 16'h0000, 32'd1000);
    row_item(waq_pkg::MODE_FINISH, 16'h0000, 32'd1000);
    // Timeouts that take the count to zero and hold it there, then a
    // dispatch while the count is zero.
    row_reg(waq_pkg::CFG_TIMEOUT, 16'd0);
    row_item(waq_pkg::MODE_ARRIVE, 16'h0003, 32'd100);
    row_item(waq_pkg::MODE_ARRIVE, 16'h0004, 32'd100);
    row_item(waq_pkg::MODE_FINISH, 16'h0000, 32'd101);
    row_item(waq_pkg::MODE_FINISH, 16'h0000, 32'd101);
    row_item(waq_pkg::MODE_ARRIVE, 16'h0005, 32'd200);
    row_item(waq_pkg::MODE_ARRIVE, 16'h0006, 32'd200);
    row_item(waq_pkg::MODE_ARRIVE, 16'h0007, 32'd200);
    row_item(waq_pkg::MODE_FINISH, 16'h0000, 32'd201);
    row_item(waq_pkg::MODE_FINISH, 16'h0000, 32'd200);

    // Reset is applied once, here, and released on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (int r = 0; r < script_len; r++) begin
      if (script[r].is_reg) write_reg(script[r].reg_idx, script[r].reg_val);
      else send_item(script[r].kind, script[r].id, script[r].stamp,
                     script[r].pinned, script[r].want);
    end

    // Random phases. Small slot limits keep the line busy; the time base
    // advances by up to 1.5 s per item so short timeouts fire often, and the
    // odd fully random timestamp exercises every bit of the time field.
    clock_ms = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          // One slot, a full-depth line and heavy arrivals fill the line.
          worker_cap = 16'd1;    line_cap = 16'd0;  wait_secs = 16'd0;    arrive_pct = 80;
        end
        1: begin
          worker_cap = 16'd3;    line_cap = 16'd64; wait_secs = 16'd1;    arrive_pct = 60;
        end
        2: begin
          worker_cap = 16'd2;    line_cap = 16'd5;  wait_secs = 16'hFFFF; arrive_pct = 55;
        end
        3: begin
          worker_cap = 16'hFFFF; line_cap = 16'd7;  wait_secs = 16'd2;    arrive_pct = 50;
        end
        default: begin
          worker_cap = waq_pkg::WORKERS_W'($urandom_range(1, 6));
          line_cap   = waq_pkg::CFG_DAT_W'($urandom_range(0, 127));
          wait_secs  = waq_pkg::TIMEOUT_W'($urandom_range(0, 3));
          arrive_pct = $urandom_range(40, 75);
        end
      endcase
      write_reg(waq_pkg::CFG_MAX_WORKERS, worker_cap);
      write_reg(waq_pkg::CFG_MAX_WAITING, line_cap);
      write_reg(waq_pkg::CFG_TIMEOUT, wait_secs);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Occasionally let the pipeline run completely dry before going on.
        if ($urandom_range(0, 39) == 0) wait_for_quiet();
        clock_ms = clock_ms + $urandom_range(0, 1500);
        stamp    = ($urandom_range(0, 15) == 0) ? waq_pkg::TIME_W'($urandom) : clock_ms;
        kind     = ($urandom_range(0, 99) < arrive_pct) ? waq_pkg::MODE_ARRIVE :
                                                         waq_pkg::MODE_FINISH;
        send_item(kind, waq_pkg::ID_W'($urandom_range(0, 65535)), stamp, 1'b0, '0);
      end
    end

    // Unlimited slots: a burst with no idle cycles on either side in which
    // every arrival starts. Then the limit goes to its ceiling under a mixed
    // load of arrivals and finishes.
    no_idle = 1'b1;
    write_reg(waq_pkg::CFG_MAX_WORKERS, 16'd0);
    write_reg(waq_pkg::CFG_MAX_WAITING, 16'd0);
    repeat (BURST_ITEMS) begin
      clock_ms = clock_ms + 1;
      send_item(waq_pkg::MODE_ARRIVE, waq_pkg::ID_W'($urandom_range(0, 65535)),
                clock_ms, 1'b0, '0);
    end
    no_idle = 1'b0;
    write_reg(waq_pkg::CFG_MAX_WORKERS, 16'hFFFF);
    repeat (24) begin
      clock_ms = clock_ms + $urandom_range(0, 3000);
      kind     = ($urandom_range(0, 1) == 0) ? waq_pkg::MODE_ARRIVE : waq_pkg::MODE_FINISH;
      send_item(kind, waq_pkg::ID_W'($urandom_range(0, 65535)), clock_ms, 1'b0, '0);
    end

    wait_for_quiet();
    repeat (8) @(posedge clk);
    if (failures == 0 && want_wr == want_rd) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
